// ===== rtl/msd_pkg.sv =====
// Shared constants, record layout and bank control types for the task dispatcher.
package msd_pkg;

    localparam int TYPE_W = 10;
    localparam int DUR_W  = 16;
    localparam int TN_W   = 24;
    localparam int TIME_W = 32;
    localparam int SIDX_OUT_W = 4;
    localparam int CFG_W  = 5;

    localparam logic [1:0] KIND_LOAD  = 2'd0;
    localparam logic [1:0] KIND_TASK  = 2'd1;
    localparam logic [1:0] KIND_DRAIN = 2'd2;

    localparam logic REC_DONE  = 1'b0;
    localparam logic REC_COUNT = 1'b1;

    localparam logic [CFG_W-1:0] SERVERS_RESET = 5'd16;

    typedef struct packed {
        logic                  record_kind;
        logic [TN_W-1:0]       task_number;
        logic [TIME_W-1:0]     finish_time;
        logic [SIDX_OUT_W-1:0] server_index;
        logic [TN_W-1:0]       server_tasks;
        logic                  last;
    } t_record;

    typedef struct packed {
        logic scan_clear;
        logic scan_step;
        logic retire;
        logic place;
    } t_bank_ctl;

    typedef struct packed {
        logic best_valid;
        logic free_found;
        logic scan_last;
    } t_bank_sts;

endpackage

// ===== rtl/msd_ifs.sv =====
// Request, result and configuration channel interfaces of the task dispatcher.
interface msd_in_if;
    logic                       valid;
    logic                       ready;
    logic [1:0]                 kind;
    logic [msd_pkg::TYPE_W-1:0] task_type;
    logic [msd_pkg::DUR_W-1:0]  duration;

    modport source (output valid, kind, task_type, duration, input ready);
    modport sink (input valid, kind, task_type, duration, output ready);
endinterface

interface msd_out_if;
    logic                           valid;
    logic                           ready;
    logic                           record_kind;
    logic [msd_pkg::TN_W-1:0]       task_number;
    logic [msd_pkg::TIME_W-1:0]     finish_time;
    logic [msd_pkg::SIDX_OUT_W-1:0] server_index;
    logic [msd_pkg::TN_W-1:0]       server_tasks;
    logic                           last;

    modport source (output valid, record_kind, task_number, finish_time, server_index,
                    server_tasks, last, input ready);
    modport sink (input valid, record_kind, task_number, finish_time, server_index,
                  server_tasks, last, output ready);
endinterface

interface msd_cfg_if;
    logic                      valid;
    logic                      ready;
    logic [msd_pkg::CFG_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

// ===== rtl/msd_server_bank.sv =====
// Server state bank with the shared minimum-finish scan unit and free-slot encoder.
module msd_server_bank #(
    parameter int SERVERS = 16,
    parameter int SIDX_W  = (SERVERS > 1) ? $clog2(SERVERS) : 1,
    parameter int CNT_W   = $clog2(SERVERS + 1)
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  msd_pkg::t_bank_ctl          i_ctl,
    input  logic [CNT_W-1:0]            i_limit,
    input  logic [msd_pkg::TN_W-1:0]    i_place_task,
    input  logic [msd_pkg::TIME_W-1:0]  i_place_finish,
    output msd_pkg::t_bank_sts          o_sts,
    output logic [CNT_W-1:0]            o_busy_cnt,
    output logic [SIDX_W-1:0]           o_best_idx,
    output logic [msd_pkg::TIME_W-1:0]  o_best_fin,
    output logic [msd_pkg::TN_W-1:0]    o_best_task,
    output logic [SIDX_W-1:0]           o_scan_idx,
    output logic [msd_pkg::TN_W-1:0]    o_scan_count
);

    logic [SERVERS-1:0]          r_busy;
    logic [msd_pkg::TIME_W-1:0]  r_fin  [SERVERS];
    logic [msd_pkg::TN_W-1:0]    r_task [SERVERS];
    logic [msd_pkg::TN_W-1:0]    r_cnt  [SERVERS];
    logic [SIDX_W-1:0]           r_idx;
    logic                        r_best_v;
    logic [SIDX_W-1:0]           r_best_idx;
    logic [msd_pkg::TIME_W-1:0]  r_best_fin;
    logic [msd_pkg::TN_W-1:0]    r_best_task;

    logic              w_scan_last;
    logic              w_better;
    logic              w_free_found;
    logic [SIDX_W-1:0] w_free_idx;
    logic [CNT_W-1:0]  w_busy_cnt;

    assign w_scan_last = (r_idx == SIDX_W'(SERVERS - 1));

    // Ties on finish time go to the lower task number.
    assign w_better = r_busy[r_idx] &&
                      (!r_best_v || (r_fin[r_idx] < r_best_fin) ||
                       ((r_fin[r_idx] == r_best_fin) && (r_task[r_idx] < r_best_task)));

    always_comb begin
        w_free_found = 1'b0;
        w_free_idx   = '0;
        w_busy_cnt   = '0;
        for (int i = SERVERS - 1; i >= 0; i--) begin
            if ((CNT_W'(i) < i_limit) && !r_busy[i]) begin
                w_free_found = 1'b1;
                w_free_idx   = SIDX_W'(i);
            end
        end
        for (int i = 0; i < SERVERS; i++) begin
            w_busy_cnt = w_busy_cnt + CNT_W'(r_busy[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= '0;
            r_idx    <= '0;
            r_best_v <= 1'b0;
            for (int i = 0; i < SERVERS; i++) begin
                r_cnt[i] <= '0;
            end
        end else begin
            if (i_ctl.scan_clear) begin
                r_idx    <= '0;
                r_best_v <= 1'b0;
            end else if (i_ctl.scan_step) begin
                if (w_better) begin
                    r_best_v <= 1'b1;
                end
                r_idx <= w_scan_last ? '0 : r_idx + SIDX_W'(1);
            end
            if (i_ctl.retire) begin
                r_busy[r_best_idx] <= 1'b0;
            end
            if (i_ctl.place) begin
                r_busy[w_free_idx] <= 1'b1;
                if (r_cnt[w_free_idx] != '1) begin
                    r_cnt[w_free_idx] <= r_cnt[w_free_idx] + msd_pkg::TN_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_ctl.scan_clear && i_ctl.scan_step && w_better) begin
            r_best_idx  <= r_idx;
            r_best_fin  <= r_fin[r_idx];
            r_best_task <= r_task[r_idx];
        end
        if (i_ctl.place) begin
            r_fin[w_free_idx]  <= i_place_finish;
            r_task[w_free_idx] <= i_place_task;
        end
    end

    assign o_sts.best_valid = r_best_v;
    assign o_sts.free_found = w_free_found;
    assign o_sts.scan_last  = w_scan_last;
    assign o_busy_cnt   = w_busy_cnt;
    assign o_best_idx   = r_best_idx;
    assign o_best_fin   = r_best_fin;
    assign o_best_task  = r_best_task;
    assign o_scan_idx   = r_idx;
    assign o_scan_count = r_cnt[r_idx];

endmodule

// ===== rtl/multi_server_task_dispatcher_core.sv =====
// Multi-server task dispatcher: duration table, sequencer and result register.
// A load request is written into the table; a task request checks for retirements and is then placed.
// Each retirement round and each completion runs the single min-finish scan over all servers;
// a drain retires every running task and then emits one count record per server in use.
// One request is in work at a time, and a stalled result register holds the sequencer.
// Synchronous active-low reset clears control, server state and counts, not the table.
module multi_server_task_dispatcher_core #(
    parameter int SERVERS = 16,
    parameter int TYPES   = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    msd_cfg_if.sink     i_cfg,
    msd_in_if.sink      i_item,
    msd_out_if.source   o_result
);

    localparam int SIDX_W = (SERVERS > 1) ? $clog2(SERVERS) : 1;
    localparam int CNT_W  = $clog2(SERVERS + 1);
    localparam int TIDX_W = (TYPES > 1) ? $clog2(TYPES) : 1;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_EVAL  = 3'd3;
    localparam logic [2:0] S_COUNT = 3'd4;
    localparam logic [2:0] S_FLUSH = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;

    logic [msd_pkg::CFG_W-1:0]  r_servers;
    logic [1:0]                 r_kind;
    logic [msd_pkg::TN_W-1:0]   r_next_tn;
    logic [msd_pkg::TN_W-1:0]   r_tn;
    logic [msd_pkg::TIME_W-1:0] r_lrt;
    logic                       r_first;
    logic                       r_type_ok;
    logic [msd_pkg::DUR_W-1:0]  r_rd;
    logic [msd_pkg::DUR_W-1:0]  r_table [TYPES];
    msd_pkg::t_record           r_pend;
    logic                       r_pend_v;
    msd_pkg::t_record           r_out;
    logic                       r_out_v;

    logic                        w_acc;
    logic [TIDX_W-1:0]           w_tidx;
    logic                        w_type_ok;
    logic [CNT_W-1:0]            w_limit;
    logic [msd_pkg::DUR_W-1:0]   w_dur;
    logic [msd_pkg::TIME_W:0]    w_sum;
    logic [msd_pkg::TIME_W-1:0]  w_finish;
    logic                        w_out_free;
    logic                        w_need_retire;
    logic                        w_round_end;
    logic                        w_count_end;
    msd_pkg::t_bank_ctl          w_ctl;
    msd_pkg::t_bank_sts          w_sts;
    logic [CNT_W-1:0]            w_busy_cnt;
    logic [SIDX_W-1:0]           w_best_idx;
    logic [msd_pkg::TIME_W-1:0]  w_best_fin;
    logic [msd_pkg::TN_W-1:0]    w_best_task;
    logic [SIDX_W-1:0]           w_scan_idx;
    logic [msd_pkg::TN_W-1:0]    w_scan_count;
    logic                        w_push;
    logic                        w_push_last;
    logic                        w_load_pend;
    logic                        w_clr_pend;
    logic                        w_set_first;
    logic                        w_clr_first;
    logic                        w_set_lrt;
    msd_pkg::t_record            w_pend_rec;
    msd_pkg::t_record            w_done_rec;
    msd_pkg::t_record            w_count_rec;

    msd_server_bank #(
        .SERVERS (SERVERS)
    ) u_bank (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctl          (w_ctl),
        .i_limit        (w_limit),
        .i_place_task   (r_tn),
        .i_place_finish (w_finish),
        .o_sts          (w_sts),
        .o_busy_cnt     (w_busy_cnt),
        .o_best_idx     (w_best_idx),
        .o_best_fin     (w_best_fin),
        .o_best_task    (w_best_task),
        .o_scan_idx     (w_scan_idx),
        .o_scan_count   (w_scan_count)
    );

    assign i_cfg.ready  = 1'b1;
    assign i_item.ready = (r_state == S_IDLE);
    assign w_acc        = i_item.valid && (r_state == S_IDLE);
    assign w_tidx       = TIDX_W'(i_item.task_type);
    assign w_type_ok    = (17'(i_item.task_type) < 17'(TYPES));

    // A zero setting acts as one server; settings above the built count are clipped.
    always_comb begin
        if (r_servers == '0) begin
            w_limit = CNT_W'(1);
        end else if (6'(r_servers) > 6'(SERVERS)) begin
            w_limit = CNT_W'(SERVERS);
        end else begin
            w_limit = CNT_W'(r_servers);
        end
    end

    assign w_dur      = r_type_ok ? r_rd : '0;
    assign w_sum      = {1'b0, r_lrt} + (msd_pkg::TIME_W + 1)'(w_dur);
    assign w_finish   = w_sum[msd_pkg::TIME_W] ? '1 : w_sum[msd_pkg::TIME_W-1:0];
    assign w_out_free = !r_out_v || o_result.ready;

    assign w_need_retire = (w_busy_cnt != '0) &&
                           ((r_kind == msd_pkg::KIND_DRAIN) || (w_busy_cnt >= w_limit) ||
                            !w_sts.free_found);
    assign w_round_end   = !w_sts.best_valid || (!r_first && (w_best_fin > r_lrt));
    assign w_count_end   = (CNT_W'(w_scan_idx) == (w_limit - CNT_W'(1)));

    always_comb begin
        w_done_rec              = '0;
        w_done_rec.record_kind  = msd_pkg::REC_DONE;
        w_done_rec.task_number  = w_best_task;
        w_done_rec.finish_time  = w_best_fin;
        w_done_rec.server_index = msd_pkg::SIDX_OUT_W'(w_best_idx);
        w_count_rec              = '0;
        w_count_rec.record_kind  = msd_pkg::REC_COUNT;
        w_count_rec.server_index = msd_pkg::SIDX_OUT_W'(w_scan_idx);
        w_count_rec.server_tasks = w_scan_count;
    end

    // The newest record is held back one step so the final one can be flagged last.
    always_comb begin
        n_state     = r_state;
        w_ctl       = '0;
        w_push      = 1'b0;
        w_push_last = 1'b0;
        w_load_pend = 1'b0;
        w_clr_pend  = 1'b0;
        w_set_first = 1'b0;
        w_clr_first = 1'b0;
        w_set_lrt   = 1'b0;
        w_pend_rec  = w_done_rec;
        case (r_state)
            S_IDLE: begin
                if (w_acc && ((i_item.kind == msd_pkg::KIND_TASK) ||
                              (i_item.kind == msd_pkg::KIND_DRAIN))) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (w_need_retire) begin
                    w_ctl.scan_clear = 1'b1;
                    w_set_first      = 1'b1;
                    n_state          = S_SCAN;
                end else if (r_kind == msd_pkg::KIND_TASK) begin
                    w_ctl.place = w_sts.free_found;
                    n_state     = S_FLUSH;
                end else begin
                    w_ctl.scan_clear = 1'b1;
                    n_state          = S_COUNT;
                end
            end
            S_SCAN: begin
                w_ctl.scan_step = 1'b1;
                if (w_sts.scan_last) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                if (w_round_end) begin
                    n_state = S_CHECK;
                end else if (!r_pend_v || w_out_free) begin
                    w_ctl.retire     = 1'b1;
                    w_ctl.scan_clear = 1'b1;
                    w_set_lrt        = r_first;
                    w_clr_first      = 1'b1;
                    w_push           = r_pend_v;
                    w_load_pend      = 1'b1;
                    n_state          = S_SCAN;
                end
            end
            S_COUNT: begin
                w_pend_rec = w_count_rec;
                if (!r_pend_v || w_out_free) begin
                    w_push          = r_pend_v;
                    w_load_pend     = 1'b1;
                    w_ctl.scan_step = 1'b1;
                    if (w_count_end) begin
                        n_state = S_FLUSH;
                    end
                end
            end
            S_FLUSH: begin
                if (!r_pend_v) begin
                    n_state = S_IDLE;
                end else if (w_out_free) begin
                    w_push      = 1'b1;
                    w_push_last = 1'b1;
                    w_clr_pend  = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_servers <= msd_pkg::SERVERS_RESET;
            r_next_tn <= msd_pkg::TN_W'(1);
            r_lrt     <= '0;
            r_first   <= 1'b0;
            r_pend_v  <= 1'b0;
            r_out_v   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg.valid) begin
                r_servers <= i_cfg.data;
            end
            if (w_acc && (i_item.kind == msd_pkg::KIND_TASK)) begin
                r_next_tn <= r_next_tn + msd_pkg::TN_W'(1);
            end
            if (w_set_lrt) begin
                r_lrt <= w_best_fin;
            end
            if (w_set_first) begin
                r_first <= 1'b1;
            end else if (w_clr_first) begin
                r_first <= 1'b0;
            end
            if (w_load_pend) begin
                r_pend_v <= 1'b1;
            end else if (w_clr_pend) begin
                r_pend_v <= 1'b0;
            end
            if (w_push) begin
                r_out_v <= 1'b1;
            end else if (o_result.ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_kind    <= i_item.kind;
            r_tn      <= r_next_tn;
            r_type_ok <= w_type_ok;
        end
        if (w_acc && (i_item.kind == msd_pkg::KIND_LOAD) && w_type_ok) begin
            r_table[w_tidx] <= i_item.duration;
        end
        if (w_acc && (i_item.kind == msd_pkg::KIND_TASK)) begin
            r_rd <= r_table[w_tidx];
        end
        if (w_load_pend) begin
            r_pend <= w_pend_rec;
        end
        if (w_push) begin
            r_out <= {r_pend[$bits(msd_pkg::t_record)-1:1], w_push_last};
        end
    end

    assign o_result.valid        = r_out_v;
    assign o_result.record_kind  = r_out.record_kind;
    assign o_result.task_number  = r_out.task_number;
    assign o_result.finish_time  = r_out.finish_time;
    assign o_result.server_index = r_out.server_index;
    assign o_result.server_tasks = r_out.server_tasks;
    assign o_result.last         = r_out.last;

`ifndef SYNTHESIS
    // A record is only moved into the result register when that register can take it.
    a_push_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> w_out_free)
        else $error("result register overwritten while still holding a record");

    // Count records are only produced after every running task has been retired.
    a_count_after_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_COUNT) |-> (w_busy_cnt == '0))
        else $error("count records started with servers still busy");

    // With no server busy there is always a free server within the limit.
    a_idle_bank_has_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_CHECK) && (w_busy_cnt == '0)) |-> w_sts.free_found)
        else $error("no free server found although none is busy");
`endif

endmodule

// ===== tb/sv/tb_multi_server_task_dispatcher_core.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the multi-server task dispatcher core.
module tb_multi_server_task_dispatcher_core;

    localparam int NSRV  = 16;
    localparam int NTYPE = 1024;
    localparam int SETTLE_CYCLES = 80;
    localparam logic [1:0] KIND_NONE = 2'd3;

    logic i_clk = 1'b0;
    logic i_rst_n;

    always #6 i_clk = ~i_clk;

    msd_in_if  item_if ();
    msd_out_if result_if ();
    msd_cfg_if cfg_if ();

    multi_server_task_dispatcher_core #(
        .SERVERS(NSRV),
        .TYPES  (NTYPE)
    ) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_if),
        .i_item  (item_if),
        .o_result(result_if)
    );

    // Shadow copy of the dispatcher state.
    logic [msd_pkg::DUR_W-1:0]  type_duration [NTYPE];
    bit                         type_loaded [NTYPE];
    int                         loaded_types [$];
    bit                         srv_busy [NSRV];
    logic [msd_pkg::TIME_W-1:0] srv_finish [NSRV];
    logic [msd_pkg::TN_W-1:0]   srv_task [NSRV];
    logic [msd_pkg::TN_W-1:0]   srv_count [NSRV];
    logic [msd_pkg::TIME_W-1:0] retire_time;
    logic [msd_pkg::TN_W-1:0]   next_task;
    logic [msd_pkg::CFG_W-1:0]  servers_reg;

    msd_pkg::t_record due_records [$];
    msd_pkg::t_record held;
    bit      have_held;
    int      mismatches = 0;
    bit      no_idle = 1'b0;

    logic        res_ready = 1'b1;
    int unsigned res_gap = 0;

    assign result_if.ready = res_ready;

    function automatic int limit_now();
        int m = servers_reg;
        if (m < 1) begin
            m = 1;
        end
        if (m > NSRV) begin
            m = NSRV;
        end
        return m;
    endfunction

    function automatic int earliest_busy();
        int best = -1;
        for (int i = 0; i < NSRV; i++) begin
            if (srv_busy[i] && (best < 0 || srv_finish[i] < srv_finish[best] ||
                    (srv_finish[i] == srv_finish[best] && srv_task[i] < srv_task[best]))) begin
                best = i;
            end
        end
        return best;
    endfunction

    function automatic int busy_count();
        int c = 0;
        for (int i = 0; i < NSRV; i++) begin
            if (srv_busy[i]) begin
                c++;
            end
        end
        return c;
    endfunction

    function automatic int free_slot(int m);
        for (int i = 0; i < m; i++) begin
            if (!srv_busy[i]) begin
                return i;
            end
        end
        return -1;
    endfunction

    function automatic msd_pkg::t_record make_record(logic rk, logic [msd_pkg::TN_W-1:0] tn,
                                                     logic [msd_pkg::TIME_W-1:0] ft,
                                                     logic [3:0] si,
                                                     logic [msd_pkg::TN_W-1:0] st);
        msd_pkg::t_record r;
        r.record_kind  = rk;
        r.task_number  = tn;
        r.finish_time  = ft;
        r.server_index = si;
        r.server_tasks = st;
        r.last         = 1'b0;
        return r;
    endfunction

    // Records are held back by one so that the final one of a request can carry last.
    task automatic emit(msd_pkg::t_record r);
        if (have_held) begin
            due_records = {due_records, held};
        end
        held = r;
        have_held = 1'b1;
    endtask

    task automatic retire_round();
        bit first = 1'b1;
        int s;
        forever begin
            s = earliest_busy();
            if (s < 0) begin
                break;
            end
            if (!first && srv_finish[s] > retire_time) begin
                break;
            end
            if (first) begin
                retire_time = srv_finish[s];
            end
            first = 1'b0;
            emit(make_record(msd_pkg::REC_DONE, srv_task[s], srv_finish[s], 4'(s), '0));
            srv_busy[s] = 1'b0;
        end
    endtask

    task automatic advance_schedule(logic [1:0] kind, logic [msd_pkg::TYPE_W-1:0] ttype,
                                    logic [msd_pkg::DUR_W-1:0] dur);
        int m = limit_now();
        int s;
        logic [msd_pkg::TIME_W:0] f;
        case (kind)
            msd_pkg::KIND_LOAD: begin
                type_duration[ttype] = dur;
                if (!type_loaded[ttype]) begin
                    type_loaded[ttype] = 1'b1;
                    loaded_types = {loaded_types, int'(ttype)};
                end
            end
            msd_pkg::KIND_TASK: begin
                while (busy_count() > 0 && (busy_count() >= m || free_slot(m) < 0)) begin
                    retire_round();
                end
                s = free_slot(m);
                if (s >= 0) begin
                    f = {1'b0, retire_time} + type_duration[ttype];
                    srv_busy[s]   = 1'b1;
                    srv_finish[s] = f[msd_pkg::TIME_W] ? '1 : f[msd_pkg::TIME_W-1:0];
                    srv_task[s]   = next_task;
                    if (srv_count[s] != '1) begin
                        srv_count[s]++;
                    end
                end
                next_task++;
            end
            msd_pkg::KIND_DRAIN: begin
                while (busy_count() > 0) begin
                    retire_round();
                end
                for (int i = 0; i < m; i++) begin
                    emit(make_record(msd_pkg::REC_COUNT, '0, '0, 4'(i), srv_count[i]));
                end
            end
            default: begin
            end
        endcase
        if (have_held) begin
            held.last = 1'b1;
            due_records = {due_records, held};
            have_held = 1'b0;
        end
    endtask

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        if (mismatches < 200) begin
            $display("%0t: mismatch in %s: got %0d, expected %0d", $time, what, got, want);
        end
        mismatches++;
    endtask

    task automatic send_item(logic [1:0] kind, logic [msd_pkg::TYPE_W-1:0] ttype,
                             logic [msd_pkg::DUR_W-1:0] dur);
        int unsigned gap = no_idle ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            item_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        item_if.valid     <= 1'b1;
        item_if.kind      <= kind;
        item_if.task_type <= ttype;
        item_if.duration  <= dur;
        do @(posedge i_clk); while (!item_if.ready);
        advance_schedule(kind, ttype, dur);
    endtask

    task automatic wait_all_done();
        item_if.valid <= 1'b0;
        do @(posedge i_clk); while (due_records.size() > 0);
    endtask

    // A request that yields no record may still be in work; give it time to finish.
    task automatic settle();
        wait_all_done();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_servers(logic [msd_pkg::CFG_W-1:0] value);
        settle();
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= value;
        do @(posedge i_clk); while (!cfg_if.ready);
        servers_reg = value;
        cfg_if.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [msd_pkg::TYPE_W-1:0] known_type();
        return msd_pkg::TYPE_W'(loaded_types[$urandom_range(0, loaded_types.size() - 1)]);
    endfunction

    task automatic test_directed_basics();
        write_servers(5'd2);
        send_item(msd_pkg::KIND_LOAD, 10'd0, 16'd0);
        send_item(msd_pkg::KIND_LOAD, 10'd1023, 16'hFFFF);
        send_item(msd_pkg::KIND_LOAD, 10'h155, 16'hAAAA);
        send_item(msd_pkg::KIND_LOAD, 10'h2AA, 16'h5555);
        send_item(msd_pkg::KIND_LOAD, 10'd1, 16'd5);
        send_item(msd_pkg::KIND_LOAD, 10'd2, 16'd5);
        send_item(msd_pkg::KIND_LOAD, 10'd3, 16'd3);
        // Tasks one and two tie on finish time and retire by task number.
        send_item(msd_pkg::KIND_TASK, 10'd1, 16'd0);
        send_item(msd_pkg::KIND_TASK, 10'd2, 16'hFFFF);
        send_item(msd_pkg::KIND_TASK, 10'd3, 16'd0);
        send_item(msd_pkg::KIND_TASK, 10'd0, 16'd0);
        send_item(msd_pkg::KIND_TASK, 10'd1023, 16'd0);
        send_item(KIND_NONE, 10'h3FF, 16'hFFFF);
        send_item(msd_pkg::KIND_TASK, 10'h155, 16'd0);
        send_item(msd_pkg::KIND_TASK, 10'h2AA, 16'd0);
        send_item(msd_pkg::KIND_DRAIN, 10'd0, 16'd0);
        send_item(msd_pkg::KIND_TASK, 10'd3, 16'd0);
        send_item(msd_pkg::KIND_DRAIN, 10'h3FF, 16'hFFFF);
    endtask

    task automatic test_register_extremes();
        write_servers(5'd0);
        send_item(msd_pkg::KIND_TASK, 10'd1, 16'd0);
        send_item(msd_pkg::KIND_TASK, 10'd3, 16'd0);
        send_item(msd_pkg::KIND_TASK, 10'd2, 16'd0);
        send_item(msd_pkg::KIND_DRAIN, 10'd0, 16'd0);
        write_servers(5'd31);
        for (int i = 0; i < 4; i++) begin
            send_item(msd_pkg::KIND_TASK, known_type(), 16'(i));
        end
        send_item(msd_pkg::KIND_DRAIN, 10'd0, 16'd0);
        write_servers(5'd17);
        send_item(msd_pkg::KIND_TASK, 10'd3, 16'd0);
        send_item(msd_pkg::KIND_TASK, 10'd1, 16'd0);
        send_item(msd_pkg::KIND_DRAIN, 10'd0, 16'd0);
    endtask

    task automatic test_lowered_limit();
        write_servers(5'd16);
        for (int i = 0; i < 10; i++) begin
            send_item(msd_pkg::KIND_TASK, (i % 2 == 0) ? 10'd3 : 10'd1, 16'd0);
        end
        // Servers at and above the new limit keep running and still count as busy.
        write_servers(5'd3);
        for (int i = 0; i < 3; i++) begin
            send_item(msd_pkg::KIND_TASK, 10'd2, 16'd0);
        end
        write_servers(5'd16);
        send_item(msd_pkg::KIND_TASK, 10'd1, 16'd0);
        send_item(msd_pkg::KIND_TASK, 10'd0, 16'd0);
        send_item(msd_pkg::KIND_DRAIN, 10'd0, 16'd0);
    endtask

    task automatic test_random_traffic();
        logic [msd_pkg::CFG_W-1:0] phase_servers [10] = '{5'd16, 5'd1, 5'd4, 5'd31, 5'd0,
                                                          5'd7, 5'd2, 5'd17, 5'd12, 5'd16};
        int counted;
        int unsigned r;
        logic [msd_pkg::TYPE_W-1:0] ttype;
        logic [msd_pkg::DUR_W-1:0]  dur;
        for (int p = 0; p < 10; p++) begin
            write_servers(phase_servers[p]);
            no_idle = (p == 3 || p == 7);
            counted = 0;
            while (counted < 38) begin
                r = $urandom_range(0, 99);
                dur = 16'($urandom);
                if (r < 20) begin
                    ttype = ($urandom_range(0, 99) < 70) ? 10'($urandom_range(0, 31))
                                                         : 10'($urandom_range(0, 1023));
                    case ($urandom_range(0, 9))
                        0, 1, 2, 3, 4, 5: dur = 16'($urandom_range(0, 15));
                        6, 7, 8:          dur = 16'($urandom_range(0, 1000));
                        default:          dur = 16'($urandom);
                    endcase
                    send_item(msd_pkg::KIND_LOAD, ttype, dur);
                    counted++;
                end else if (r < 85) begin
                    send_item(msd_pkg::KIND_TASK, known_type(), dur);
                    counted++;
                end else if (r < 92) begin
                    send_item(msd_pkg::KIND_DRAIN, 10'($urandom), dur);
                    counted++;
                end else begin
                    send_item(KIND_NONE, 10'($urandom), dur);
                end
                if ($urandom_range(0, 29) == 0) begin
                    wait_all_done();
                end
            end
            if ($urandom_range(0, 1) == 1) begin
                send_item(msd_pkg::KIND_DRAIN, 10'd0, 16'd0);
            end
        end
        no_idle = 1'b0;
    endtask

    // Result side back-pressure: a random wait before taking each record.
    always @(posedge i_clk) begin
        int unsigned g;
        if (res_gap > 0) begin
            res_gap   <= res_gap - 1;
            res_ready <= (res_gap == 1);
        end else if (result_if.valid && result_if.ready) begin
            g = no_idle ? 0 : $urandom_range(0, 3);
            res_gap   <= g;
            res_ready <= (g == 0);
        end
    end

    always @(posedge i_clk) begin
        msd_pkg::t_record want;
        if (i_rst_n === 1'b1 && result_if.valid === 1'b1 && result_if.ready === 1'b1) begin
            if (due_records.size() == 0) begin
                report_mismatch("unexpected record, task_number", result_if.task_number, 0);
            end else begin
                want = due_records.pop_front();
                if (result_if.record_kind !== want.record_kind) begin
                    report_mismatch("record_kind", result_if.record_kind, want.record_kind);
                end
                if (result_if.task_number !== want.task_number) begin
                    report_mismatch("task_number", result_if.task_number, want.task_number);
                end
                if (result_if.finish_time !== want.finish_time) begin
                    report_mismatch("finish_time", result_if.finish_time, want.finish_time);
                end
                if (result_if.server_index !== want.server_index) begin
                    report_mismatch("server_index", result_if.server_index,
                                    want.server_index);
                end
                if (result_if.server_tasks !== want.server_tasks) begin
                    report_mismatch("server_tasks", result_if.server_tasks,
                                    want.server_tasks);
                end
                if (result_if.last !== want.last) begin
                    report_mismatch("last", result_if.last, want.last);
                end
            end
        end
    end

    initial begin
        #(64'd24_000_000);
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        i_rst_n           <= 1'b0;
        item_if.valid     <= 1'b0;
        item_if.kind      <= msd_pkg::KIND_LOAD;
        item_if.task_type <= '0;
        item_if.duration  <= '0;
        cfg_if.valid      <= 1'b0;
        cfg_if.data       <= msd_pkg::SERVERS_RESET;
        for (int i = 0; i < NSRV; i++) begin
            srv_busy[i]   = 1'b0;
            srv_finish[i] = '0;
            srv_task[i]   = '0;
            srv_count[i]  = '0;
        end
        for (int i = 0; i < NTYPE; i++) begin
            type_loaded[i]   = 1'b0;
            type_duration[i] = '0;
        end
        retire_time = '0;
        next_task   = 24'd1;
        servers_reg = msd_pkg::SERVERS_RESET;
        have_held   = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_basics();
        test_register_extremes();
        test_lowered_limit();
        test_random_traffic();
        settle();

        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/msd_pkg.sv
rtl/msd_ifs.sv
rtl/msd_server_bank.sv
rtl/multi_server_task_dispatcher_core.sv
tb/sv/tb_multi_server_task_dispatcher_core.sv
